// ===== design/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DEC_BITS    = COORD_BITS + 2;
  localparam int STEP_BITS   = COORD_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic        [STEP_BITS-1:0]  step_t;

  localparam coord_t COORD_ONE = coord_t'(1);
  localparam step_t  STEP_ONE  = step_t'(1);

  typedef struct packed {
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   valid_res;
    logic   last;
  } out_item_t;

  // Classified command handed from the front end to the stepper
  typedef struct packed {
    logic   mode;
    coord_t x0;
    coord_t y0;
    dec_t   decision;
    dec_t   diag_inc;
    dec_t   straight_inc;
    step_t  steps;
    logic   x_neg;
    logic   y_neg;
    logic   x_major;
  } cmd_t;

endpackage

// ===== design/line_rasterizer.sv =====
// Bresenham line rasterizer: one pixel per item along a line between two endpoints.
//
// Input channel (in_valid / in_stall / in_item): a mode 0 item starts a new line from
// start to end and yields the start pixel; each mode 1 item yields the next pixel, with
// last set on the end pixel. A mode 1 item with no line in progress yields valid_res 0
// and zero fields. A mode 0 item drops any line still in progress.
// Result channel (out_valid / out_stall / out_item): exactly one item out per item in,
// in order.
// An accepted item is loaded into the front register, written into the queue and then
// popped into the output register that drives out_valid and out_item.
// Throughput: one item per cycle while out_stall is low, set by the single add-and-compare
// step of the stepper; line setup is pipelined in the front end.
// When the receiver stalls, the output register holds its item and the four-entry queue
// plus the front register absorb further items before in_stall rises.
// Reset (rst_n low, synchronous) empties the pipeline and queue and clears the active
// line, so the first mode 1 item after reset returns valid_res 0.
module line_rasterizer import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head;

  lr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .queue_full (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (!q_empty),
    .cmd       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== design/lr_front.sv =====
// Front end: accepts items, works out deltas, major axis and decision terms.
module lr_front import lr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     queue_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_mode_r;
  coord_t               s1_x0_r, s1_y0_r;
  step_t                s1_adx_r, s1_ady_r;
  logic                 s1_xneg_r, s1_yneg_r;

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] adx_full, ady_full;
  logic                       load;

  logic             x_major;
  step_t            major, minor;
  logic [DEC_BITS-1:0] minor2, major1, major2;

  // Stage 1: signed deltas and their magnitudes
  always_comb begin
    dx = {in_item.end_x[COORD_BITS-1], in_item.end_x}
       - {in_item.start_x[COORD_BITS-1], in_item.start_x};
    dy = {in_item.end_y[COORD_BITS-1], in_item.end_y}
       - {in_item.start_y[COORD_BITS-1], in_item.start_y};
    adx_full = dx[COORD_BITS] ? -dx : dx;
    ady_full = dy[COORD_BITS] ? -dy : dy;
  end

  assign in_stall = s1_valid_r && queue_full;
  assign load     = in_valid && !in_stall;
  assign push     = s1_valid_r && !queue_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!s1_valid_r || !queue_full) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_mode_r <= in_item.mode;
      s1_x0_r   <= in_item.start_x;
      s1_y0_r   <= in_item.start_y;
      s1_adx_r  <= adx_full[COORD_BITS-1:0];
      s1_ady_r  <= ady_full[COORD_BITS-1:0];
      s1_xneg_r <= dx[COORD_BITS];
      s1_yneg_r <= dy[COORD_BITS];
    end
  end

  // Stage 2: pick major axis (y wins a tie) and form decision terms
  always_comb begin
    x_major = s1_adx_r > s1_ady_r;
    major   = x_major ? s1_adx_r : s1_ady_r;
    minor   = x_major ? s1_ady_r : s1_adx_r;
    minor2  = {1'b0, minor, 1'b0};
    major1  = {2'b00, major};
    major2  = {1'b0, major, 1'b0};

    push_cmd.mode         = s1_mode_r;
    push_cmd.x0           = s1_x0_r;
    push_cmd.y0           = s1_y0_r;
    push_cmd.decision     = minor2 - major1;
    push_cmd.diag_inc     = minor2 - major2;
    push_cmd.straight_inc = minor2;
    push_cmd.steps        = major;
    push_cmd.x_neg        = s1_xneg_r;
    push_cmd.y_neg        = s1_yneg_r;
    push_cmd.x_major      = x_major;
  end

endmodule

// ===== design/lr_queue.sv =====
// Short command queue between front end and stepper.
module lr_queue import lr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                 entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign full  = count_r == QCNT_BITS'(QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/lr_back.sv =====
// Stepper: holds the line state; loads a line or advances it one pixel per command.
module lr_back import lr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_avail,
  input  cmd_t      cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      active_r, active_nxt;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  coord_t    cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  dec_t      decision_r, decision_nxt;
  dec_t      diag_inc_r, straight_inc_r;
  step_t     steps_r, steps_nxt;
  logic      x_neg_r, y_neg_r, x_major_r;

  logic   diag;
  coord_t x_stepped, y_stepped;

  assign pop       = cmd_avail && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    diag      = !decision_r[DEC_BITS-1];
    x_stepped = x_neg_r ? cur_x_r - COORD_ONE : cur_x_r + COORD_ONE;
    y_stepped = y_neg_r ? cur_y_r - COORD_ONE : cur_y_r + COORD_ONE;

    active_nxt   = active_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    decision_nxt = decision_r;
    steps_nxt    = steps_r;
    out_nxt      = '0;

    if (cmd.mode == MODE_START) begin
      active_nxt        = cmd.steps != '0;
      cur_x_nxt         = cmd.x0;
      cur_y_nxt         = cmd.y0;
      decision_nxt      = cmd.decision;
      steps_nxt         = cmd.steps;
      out_nxt.pixel_x   = cmd.x0;
      out_nxt.pixel_y   = cmd.y0;
      out_nxt.valid_res = 1'b1;
      out_nxt.last      = cmd.steps == '0;
    end else if (active_r) begin
      if (x_major_r) begin
        cur_x_nxt = x_stepped;
        cur_y_nxt = diag ? y_stepped : cur_y_r;
      end else begin
        cur_y_nxt = y_stepped;
        cur_x_nxt = diag ? x_stepped : cur_x_r;
      end
      decision_nxt      = decision_r + (diag ? diag_inc_r : straight_inc_r);
      steps_nxt         = steps_r - STEP_ONE;
      active_nxt        = steps_r != STEP_ONE;
      out_nxt.pixel_x   = cur_x_nxt;
      out_nxt.pixel_y   = cur_y_nxt;
      out_nxt.valid_res = 1'b1;
      out_nxt.last      = steps_r == STEP_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        active_r    <= active_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r      <= out_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      decision_r <= decision_nxt;
      steps_r    <= steps_nxt;
      if (cmd.mode == MODE_START) begin
        diag_inc_r     <= cmd.diag_inc;
        straight_inc_r <= cmd.straight_inc;
        x_neg_r        <= cmd.x_neg;
        y_neg_r        <= cmd.y_neg;
        x_major_r      <= cmd.x_major;
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the line rasterizer: directed table, random lines, scoreboard.
module testbench;
  import lr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 8;
  localparam int PHASE_ITEMS    = 600;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  line_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Line state of the predictor
  coord_t ln_cx = '0;
  coord_t ln_cy = '0;
  dec_t   ln_dec = '0;
  dec_t   ln_diag = '0;
  dec_t   ln_straight = '0;
  step_t  ln_left = '0;
  bit     ln_xneg = 1'b0;
  bit     ln_yneg = 1'b0;
  bit     ln_xmajor = 1'b0;
  bit     ln_active = 1'b0;

  out_item_t pending_pixels[$];
  stim_row_t stim_rows[$];

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int items_sent = 0;
  int lines_begun = 0;
  int pixels_seen = 0;
  int ends_seen = 0;
  int idle_seen = 0;
  int errors = 0;
  int stall_cycles = 0;
  out_item_t oldest;

  // Advances the line state by one item and returns the pixel it yields.
  function automatic out_item_t next_pixel(in_item_t it);
    int dx, dy, major, minor, sx, sy;
    bit diag;
    out_item_t r;
    r = '0;
    if (it.mode == MODE_START) begin
      dx = int'(it.end_x) - int'(it.start_x);
      dy = int'(it.end_y) - int'(it.start_y);
      ln_xneg = dx < 0;
      ln_yneg = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ln_xmajor = dx > dy;   // tie goes to y
      major = ln_xmajor ? dx : dy;
      minor = ln_xmajor ? dy : dx;
      ln_dec = dec_t'(2 * minor - major);
      ln_diag = dec_t'(2 * (minor - major));
      ln_straight = dec_t'(2 * minor);
      ln_cx = it.start_x;
      ln_cy = it.start_y;
      ln_left = step_t'(major);
      ln_active = major != 0;
      r.pixel_x = ln_cx;
      r.pixel_y = ln_cy;
      r.valid_res = 1'b1;
      r.last = !ln_active;
    end else if (ln_active) begin
      sx = ln_xneg ? -1 : 1;
      sy = ln_yneg ? -1 : 1;
      diag = ln_dec >= 0;
      if (ln_xmajor) begin
        ln_cx = coord_t'(int'(ln_cx) + sx);
        if (diag) ln_cy = coord_t'(int'(ln_cy) + sy);
      end else begin
        ln_cy = coord_t'(int'(ln_cy) + sy);
        if (diag) ln_cx = coord_t'(int'(ln_cx) + sx);
      end
      ln_dec = dec_t'(int'(ln_dec) + (diag ? int'(ln_diag) : int'(ln_straight)));
      ln_left = ln_left - STEP_ONE;
      if (ln_left == '0) ln_active = 1'b0;
      r.pixel_x = ln_cx;
      r.pixel_y = ln_cy;
      r.valid_res = 1'b1;
      r.last = !ln_active;
    end
    return r;
  endfunction

  task automatic start_row(input int sx, input int sy, input int ex, input int ey);
    stim_row_t r;
    r.item = '0;
    r.item.mode = MODE_START;
    r.item.start_x = coord_t'(sx);
    r.item.start_y = coord_t'(sy);
    r.item.end_x = coord_t'(ex);
    r.item.end_y = coord_t'(ey);
    r.typed = 1'b1;
    r.want.pixel_x = coord_t'(sx);
    r.want.pixel_y = coord_t'(sy);
    r.want.valid_res = 1'b1;
    r.want.last = (sx == ex) && (sy == ey);
    stim_rows.push_back(r);
  endtask

  // Step request; coordinates are junk the block must ignore
  task automatic next_row(input bit expect_idle);
    stim_row_t r;
    r.item = in_item_t'({$urandom, $urandom});
    r.item.mode = MODE_NEXT;
    r.typed = expect_idle;
    r.want = '0;
    stim_rows.push_back(r);
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
    pred = next_pixel(it);
    pending_pixels.push_back(typed ? want : pred);
    items_sent++;
    if (it.mode == MODE_START) lines_begun++;
    @(negedge clk);
  endtask

  function automatic int near_coord(int base, int span);
    int d, v;
    d = int'($urandom_range(0, 2 * span)) - span;
    v = base + d;
    return (v < -2048 || v > 2047) ? base - d : v;
  endfunction

  // One line: mostly walked to its end, sometimes cut short or overrun; a few stray requests.
  task automatic random_sequence();
    int pick, span, sx, sy, ex, ey, adx, ady, major, walk;
    bit far;
    in_item_t it;
    pick = $urandom_range(99);
    if (pick < 6) begin
      it = in_item_t'({$urandom, $urandom});
      it.mode = MODE_NEXT;
      send_item(it, 1'b0, '0);
      return;
    end
    far = pick < 12;
    sx = int'($urandom_range(0, 4095)) - 2048;
    sy = int'($urandom_range(0, 4095)) - 2048;
    if (far) begin
      ex = int'($urandom_range(0, 4095)) - 2048;
      ey = int'($urandom_range(0, 4095)) - 2048;
    end else begin
      span = ($urandom_range(9) == 0) ? 60 : 10;
      ex = near_coord(sx, span);
      ey = near_coord(sy, span);
    end
    adx = ex > sx ? ex - sx : sx - ex;
    ady = ey > sy ? ey - sy : sy - ey;
    major = adx > ady ? adx : ady;
    if (far) walk = $urandom_range(0, 4);
    else begin
      pick = $urandom_range(9);
      if (pick < 7) walk = major;
      else if (pick == 7) walk = major + int'($urandom_range(1, 2));
      else walk = $urandom_range(0, major);
    end
    it = in_item_t'({$urandom, $urandom});
    it.mode = MODE_START;
    it.start_x = coord_t'(sx);
    it.start_y = coord_t'(sy);
    it.end_x = coord_t'(ex);
    it.end_y = coord_t'(ey);
    send_item(it, 1'b0, '0);
    repeat (walk) begin
      it = in_item_t'({$urandom, $urandom});
      it.mode = MODE_NEXT;
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want_v,
                             input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_gap_pct);

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, got %p", $time, out_item);
      end else begin
        oldest = pending_pixels.pop_front();
        check_field("pixel_x", oldest.pixel_x, out_item.pixel_x);
        check_field("pixel_y", oldest.pixel_y, out_item.pixel_y);
        check_field("valid_res", oldest.valid_res, out_item.valid_res);
        check_field("last", oldest.last, out_item.last);
        if (!oldest.valid_res) idle_seen++;
        else pixels_seen++;
        if (oldest.last) ends_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_pixels.size());
      $display("** line_rasterizer: FAILED **");
      $finish;
    end
  end

  initial begin
    int goal;
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;

    next_row(1'b1);                            // nothing active after reset
    start_row(5, -7, 5, -7);                   // single point
    next_row(1'b1);
    start_row(-2048, -2048, 2047, 2046);       // widest x-major, near-maximal decision
    next_row(1'b0);
    next_row(1'b0);
    start_row(2047, 2047, -2048, -2048);       // diagonal tie, both steps negative
    next_row(1'b0);
    start_row(2045, -2048, 2047, -2048);       // ends on a corner
    next_row(1'b0);
    next_row(1'b0);
    next_row(1'b1);
    start_row(-2046, 2047, -2048, 2045);
    next_row(1'b0);
    next_row(1'b0);
    start_row(0, 0, 3, 1);
    next_row(1'b0);
    start_row(-1, 4, -1, -4);                  // restart mid-line, vertical
    next_row(1'b0);
    next_row(1'b0);
    start_row(-2048, 0, 2047, 0);              // full-width horizontal
    next_row(1'b0);
    start_row(7, 7, 7, 7);                     // single point drops active line
    next_row(1'b1);
    start_row(100, -100, 97, -90);
    next_row(1'b0);
    next_row(1'b0);
    next_row(1'b0);

    send_gap_pct = 7;
    recv_gap_pct = 53;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 7 : (ph == 1) ? 53 : 0;
      recv_gap_pct = (ph == 0) ? 53 : (ph == 1) ? 7 : 0;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_sequence();
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d lines begun, %0d pixels, %0d line ends,",
             items_sent, lines_begun, pixels_seen, ends_seen);
    $display("%0d step requests with no line, under three idle patterns; %0d mismatches.",
             idle_seen, errors);
    if (errors == 0) begin
      $display("** line_rasterizer: PASSED **");
    end else begin
      $display("** line_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
